### design/crc_frame_receive_parser_unit_defines.svh
`ifndef CRC_FRAME_RECEIVE_PARSER_UNIT_DEFINES_SVH
`define CRC_FRAME_RECEIVE_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CRCFRP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CRCFRP_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CRCFRP_ASSERT(label, prop, msg)
`define CRCFRP_ASSERT_NEVER(label, cond, msg)
`endif

`endif

### design/crcfrp_pkg.sv
package crcfrp_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int BYTE_W          = 8;
	localparam int LEN_OUT_W       = 6;
	localparam int IDX_OUT_W       = 5;
	localparam int M_TDATA_W       = 32;
	localparam int CFG_IDX_W       = 1;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'b1;

	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [3:0] {
		ST_HDR0,
		ST_HDR1,
		ST_CMD,
		ST_LEN,
		ST_DATA,
		ST_CRCL,
		ST_CRCH,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	typedef struct packed {
		logic crc_init;
		logic crc_upd;
		logic load_cmd;
		logic load_len;
		logic store_data;
		logic load_crc_low;
		logic clear_frame;
		logic emit_rd;
		logic emit_wr;
	} dp_cmd_t;

	typedef struct packed {
		logic hdr_first_hit;
		logic hdr_second_hit;
		logic len_too_big;
		logic len_zero;
		logic fill_done;
		logic crc_ok;
		logic emit_last;
		logic out_free;
	} dp_sts_t;

	// CRC-16/MODBUS, reflected, one byte
	function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [BYTE_W-1:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### design/crc_frame_receive_parser_unit.sv
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   s_tdata[7:0] rx_byte
// m_*       out        m_tvalid / m_tready   m_tdata, m_tlast last_of_frame
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One received byte is taken per cycle while parsing; the CRC is updated in that cycle
// for command, length and payload bytes. A good frame of L payload bytes emits max(L,1)
// results, each as a payload memory read, then a load of the output register once it is free.
// No bytes are taken during emission; the last result may wait in the output
// register while the next frame's bytes are already taken.
// Reset is asynchronous; the payload memory needs no clearing.
module crc_frame_receive_parser_unit #(
	parameter int MAX_PAYLOAD = crcfrp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [crcfrp_pkg::BYTE_W-1:0]         s_tdata,    // [7:0] rx_byte
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [7:0] frame_command, [13:8] frame_length, [21:14] data_byte,
	// [26:22] byte_index, [31:27] zero
	output logic [crcfrp_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [crcfrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crcfrp_pkg::BYTE_W-1:0]         cfg_data
);

	crcfrp_pkg::dp_cmd_t cmd;
	crcfrp_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	crcfrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	crcfrp_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### design/crcfrp_ram.sv
module crcfrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/crcfrp_ctrl.sv
`include "crc_frame_receive_parser_unit_defines.svh"

module crcfrp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  crcfrp_pkg::dp_sts_t sts,
	output crcfrp_pkg::dp_cmd_t cmd
);

	crcfrp_pkg::state_t state_q;
	crcfrp_pkg::state_t state_nxt;
	logic               acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crcfrp_pkg::ST_HDR0;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q != crcfrp_pkg::ST_EMIT_RD) && (state_q != crcfrp_pkg::ST_EMIT_WR);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			crcfrp_pkg::ST_HDR0: begin
				if (acc && sts.hdr_first_hit) begin
					state_nxt = crcfrp_pkg::ST_HDR1;
				end
			end
			crcfrp_pkg::ST_HDR1: begin
				if (acc) begin
					if (sts.hdr_second_hit) begin
						cmd.crc_init = 1'b1;
						state_nxt    = crcfrp_pkg::ST_CMD;
					end else if (!sts.hdr_first_hit) begin
						state_nxt = crcfrp_pkg::ST_HDR0;
					end
				end
			end
			crcfrp_pkg::ST_CMD: begin
				if (acc) begin
					cmd.load_cmd = 1'b1;
					cmd.crc_upd  = 1'b1;
					state_nxt    = crcfrp_pkg::ST_LEN;
				end
			end
			crcfrp_pkg::ST_LEN: begin
				if (acc) begin
					if (sts.len_too_big) begin
						cmd.clear_frame = 1'b1;
						state_nxt       = crcfrp_pkg::ST_HDR0;
					end else begin
						cmd.load_len = 1'b1;
						cmd.crc_upd  = 1'b1;
						state_nxt    = sts.len_zero ? crcfrp_pkg::ST_CRCL : crcfrp_pkg::ST_DATA;
					end
				end
			end
			crcfrp_pkg::ST_DATA: begin
				if (acc) begin
					cmd.store_data = 1'b1;
					cmd.crc_upd    = 1'b1;
					if (sts.fill_done) begin
						state_nxt = crcfrp_pkg::ST_CRCL;
					end
				end
			end
			crcfrp_pkg::ST_CRCL: begin
				if (acc) begin
					cmd.load_crc_low = 1'b1;
					state_nxt        = crcfrp_pkg::ST_CRCH;
				end
			end
			crcfrp_pkg::ST_CRCH: begin
				if (acc) begin
					if (sts.crc_ok) begin
						state_nxt = crcfrp_pkg::ST_EMIT_RD;
					end else begin
						cmd.clear_frame = 1'b1;
						state_nxt       = crcfrp_pkg::ST_HDR0;
					end
				end
			end
			crcfrp_pkg::ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_nxt   = crcfrp_pkg::ST_EMIT_WR;
			end
			crcfrp_pkg::ST_EMIT_WR: begin
				if (sts.out_free) begin
					cmd.emit_wr = 1'b1;
					if (sts.emit_last) begin
						cmd.clear_frame = 1'b1;
						state_nxt       = crcfrp_pkg::ST_HDR0;
					end else begin
						state_nxt = crcfrp_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				cmd.clear_frame = 1'b1;
				state_nxt       = crcfrp_pkg::ST_HDR0;
			end
		endcase
	end

	`CRCFRP_ASSERT(a_bad_crc_drops, (state_q == crcfrp_pkg::ST_CRCH && acc && !sts.crc_ok) |=> (state_q == crcfrp_pkg::ST_HDR0), "bad frame not dropped")
	`CRCFRP_ASSERT(a_long_len_drops, (state_q == crcfrp_pkg::ST_LEN && acc && sts.len_too_big) |=> (state_q == crcfrp_pkg::ST_HDR0), "oversize frame not dropped")

endmodule

### design/crcfrp_dp.sv
`include "crc_frame_receive_parser_unit_defines.svh"

module crcfrp_dp #(
	parameter int MAX_PAYLOAD = crcfrp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [crcfrp_pkg::BYTE_W-1:0]         s_tdata,
	input  logic                                  cfg_valid,
	input  logic [crcfrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crcfrp_pkg::BYTE_W-1:0]         cfg_data,
	input  crcfrp_pkg::dp_cmd_t                   cmd,
	output crcfrp_pkg::dp_sts_t                   sts,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [crcfrp_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                  m_tlast
);

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [crcfrp_pkg::BYTE_W-1:0]    hdr_first_q;
	logic [crcfrp_pkg::BYTE_W-1:0]    hdr_second_q;
	logic [crcfrp_pkg::BYTE_W-1:0]    cmd_q;
	logic [LEN_W-1:0]                 len_q;
	logic [LEN_W-1:0]                 fill_q;
	logic [LEN_W-1:0]                 fill_nxt;
	logic [crcfrp_pkg::BYTE_W-1:0]    crc_low_q;
	logic [15:0]                      crc_q;
	logic [AW-1:0]                    k_q;
	logic [LEN_W-1:0]                 emit_n;
	logic [crcfrp_pkg::BYTE_W-1:0]    ram_rd_data;
	logic [31:0]                      len_wide;
	logic [31:0]                      k_wide;

	logic                             m_valid_q;
	logic [crcfrp_pkg::BYTE_W-1:0]    m_cmd_q;
	logic [crcfrp_pkg::LEN_OUT_W-1:0] m_len_q;
	logic [crcfrp_pkg::BYTE_W-1:0]    m_data_q;
	logic [crcfrp_pkg::IDX_OUT_W-1:0] m_idx_q;
	logic                             m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q  <= crcfrp_pkg::HEADER_FIRST_RST;
			hdr_second_q <= crcfrp_pkg::HEADER_SECOND_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				crcfrp_pkg::REG_HEADER_FIRST:  hdr_first_q  <= cfg_data;
				crcfrp_pkg::REG_HEADER_SECOND: hdr_second_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign fill_nxt = fill_q + LEN_W'(1);
	assign emit_n   = (len_q == '0) ? LEN_W'(1) : len_q;
	assign len_wide = 32'(len_q);
	assign k_wide   = 32'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			len_q     <= '0;
			fill_q    <= '0;
			crc_low_q <= '0;
			crc_q     <= crcfrp_pkg::CRC_INIT;
			k_q       <= '0;
		end else if (cmd.clear_frame) begin
			cmd_q     <= '0;
			len_q     <= '0;
			fill_q    <= '0;
			crc_low_q <= '0;
			crc_q     <= crcfrp_pkg::CRC_INIT;
			k_q       <= '0;
		end else begin
			if (cmd.crc_init) begin
				crc_q <= crcfrp_pkg::CRC_INIT;
			end else if (cmd.crc_upd) begin
				crc_q <= crcfrp_pkg::crc16_update(crc_q, s_tdata);
			end
			if (cmd.load_cmd) begin
				cmd_q <= s_tdata;
			end
			if (cmd.load_len) begin
				len_q  <= s_tdata[LEN_W-1:0];
				fill_q <= '0;
			end
			if (cmd.store_data) begin
				fill_q <= fill_nxt;
			end
			if (cmd.load_crc_low) begin
				crc_low_q <= s_tdata;
			end
			if (cmd.emit_wr) begin
				k_q <= k_q + AW'(1);
			end
		end
	end

	crcfrp_ram #(
		.WIDTH (crcfrp_pkg::BYTE_W),
		.DEPTH (MAX_PAYLOAD),
		.AW    (AW)
	) u_payload (
		.clk     (clk),
		.wr_en   (cmd.store_data),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (s_tdata),
		.rd_en   (cmd.emit_rd),
		.rd_addr (k_q),
		.rd_data (ram_rd_data)
	);

	always_comb begin
		sts.hdr_first_hit  = (s_tdata == hdr_first_q);
		sts.hdr_second_hit = (s_tdata == hdr_second_q);
		sts.len_too_big    = (s_tdata > crcfrp_pkg::BYTE_W'(MAX_PAYLOAD));
		sts.len_zero       = (s_tdata == '0);
		sts.fill_done      = (fill_nxt >= len_q);
		sts.crc_ok         = (crc_low_q == crc_q[7:0]) && (s_tdata == crc_q[15:8]);
		sts.emit_last      = ((LEN_W'(k_q) + LEN_W'(1)) == emit_n);
		sts.out_free       = !m_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit_wr) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_wr) begin
			m_cmd_q  <= cmd_q;
			m_len_q  <= len_wide[crcfrp_pkg::LEN_OUT_W-1:0];
			m_data_q <= (len_q == '0) ? '0 : ram_rd_data;
			m_idx_q  <= k_wide[crcfrp_pkg::IDX_OUT_W-1:0];
			m_last_q <= sts.emit_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {5'b0, m_idx_q, m_data_q, m_len_q, m_cmd_q};

	`CRCFRP_ASSERT_NEVER(a_fill_bounded, fill_q > len_q, "payload fill ran past frame length")
	`CRCFRP_ASSERT_NEVER(a_emit_bounded, LEN_W'(k_q) >= emit_n, "emit index ran past frame length")

endmodule

### tb/crc_frame_receive_parser_unit_checker.sv
`timescale 1ns / 1ps
package crcfrp_tb_pkg;

	function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ crcfrp_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

module crc_frame_receive_parser_unit_checker
	import crcfrp_pkg::*;
	import crcfrp_tb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 m_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	output int                   err_count,
	output int                   pending
);

	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		TAKE_CMD,
		TAKE_LEN,
		TAKE_PAYLOAD,
		TAKE_CRC_LO,
		TAKE_CRC_HI
	} parse_phase_e;

	typedef struct packed {
		logic [7:0] cmd;
		logic [5:0] len;
		logic [7:0] data;
		logic [4:0] idx;
		logic       last;
	} frame_result_t;

	logic [BYTE_W-1:0] hdr_first_reg;
	logic [BYTE_W-1:0] hdr_second_reg;
	parse_phase_e      phase;
	logic [7:0]        cmd_q;
	logic [5:0]        len_q;
	logic [7:0]        payload_mem [MAX_PAYLOAD_DEF];
	logic [5:0]        fill_q;
	logic [7:0]        crc_lo_q;
	logic [15:0]       crc_q;
	frame_result_t     result_fifo [$];
	frame_result_t     want;

	task clear_parse();
		phase    = HUNT_FIRST;
		cmd_q    = '0;
		len_q    = '0;
		fill_q   = '0;
		crc_lo_q = '0;
		crc_q    = CRC_INIT;
	endtask

	task check_field(input string name, input int unsigned exp_val, input int unsigned got_val);
		if (exp_val != got_val) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
		end
	endtask

	task take_byte(input logic [7:0] b);
		frame_result_t r;
		int            n;
		case (phase)
			HUNT_FIRST: begin
				if (b == hdr_first_reg) begin
					phase = HUNT_SECOND;
				end
			end
			HUNT_SECOND: begin
				if (b == hdr_second_reg) begin
					crc_q = CRC_INIT;
					phase = TAKE_CMD;
				end else if (b != hdr_first_reg) begin
					phase = HUNT_FIRST;
				end
			end
			TAKE_CMD: begin
				cmd_q = b;
				crc_q = modbus_crc_step(crc_q, b);
				phase = TAKE_LEN;
			end
			TAKE_LEN: begin
				fill_q = '0;
				if (b > MAX_PAYLOAD_DEF) begin
					clear_parse();
				end else begin
					len_q = b[5:0];
					crc_q = modbus_crc_step(crc_q, b);
					phase = (b == 8'd0) ? TAKE_CRC_LO : TAKE_PAYLOAD;
				end
			end
			TAKE_PAYLOAD: begin
				payload_mem[fill_q[4:0]] = b;
				crc_q = modbus_crc_step(crc_q, b);
				fill_q++;
				if (fill_q >= len_q) begin
					phase = TAKE_CRC_LO;
				end
			end
			TAKE_CRC_LO: begin
				crc_lo_q = b;
				phase = TAKE_CRC_HI;
			end
			TAKE_CRC_HI: begin
				if ({b, crc_lo_q} == crc_q) begin
					n = (len_q == 0) ? 1 : len_q;
					for (int k = 0; k < n; k++) begin
						r.cmd  = cmd_q;
						r.len  = len_q;
						r.data = (len_q != 0) ? payload_mem[k] : 8'd0;
						r.idx  = k[4:0];
						r.last = (k == n - 1);
						result_fifo.push_back(r);
					end
				end
				clear_parse();
			end
			default: begin
				clear_parse();
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_reg = HEADER_FIRST_RST;
			hdr_second_reg = HEADER_SECOND_RST;
			clear_parse();
			result_fifo.delete();
			err_count = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_fifo.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
						$time, m_tdata, m_tlast);
				end else begin
					want = result_fifo.pop_front();
					check_field("frame_command", 32'(want.cmd), 32'(m_tdata[7:0]));
					check_field("frame_length", 32'(want.len), 32'(m_tdata[13:8]));
					check_field("data_byte", 32'(want.data), 32'(m_tdata[21:14]));
					check_field("byte_index", 32'(want.idx), 32'(m_tdata[26:22]));
					check_field("tdata padding", 0, 32'(m_tdata[31:27]));
					check_field("last_of_frame", 32'(want.last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready) begin
				take_byte(s_tdata);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_HEADER_FIRST) begin
					hdr_first_reg = cfg_data;
				end else if (cfg_index == REG_HEADER_SECOND) begin
					hdr_second_reg = cfg_data;
				end
			end
			pending = result_fifo.size();
		end
	end

endmodule

### tb/crc_frame_receive_parser_unit_tb.sv
`timescale 1ns / 1ps
module crc_frame_receive_parser_unit_tb;
	import crcfrp_pkg::*;
	import crcfrp_tb_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	int                   err_count;
	int                   pending;

	int         tx_idle_pct = 20;
	int         rx_idle_pct = 86;
	int         rx_hold_req = 0;
	logic [7:0] hdr_first = HEADER_FIRST_RST;
	logic [7:0] hdr_second = HEADER_SECOND_RST;
	logic [7:0] byte_q [$];

	always #5 clk = ~clk;

	crc_frame_receive_parser_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	crc_frame_receive_parser_unit_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.err_count (err_count),
		.pending   (pending)
	);

	function int pick_payload_len();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(24, MAX_PAYLOAD_DEF);
		end
		return $urandom_range(0, 6);
	endfunction

	task push_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task send_queued();
		while (byte_q.size() > 0) begin
			push_byte(byte_q.pop_front());
		end
	endtask

	task add_frame(input logic [7:0] cmd, input int len, input int fill, input bit corrupt);
		logic [15:0] crc;
		logic [7:0]  d;
		crc = CRC_INIT;
		byte_q.push_back(hdr_first);
		byte_q.push_back(hdr_second);
		byte_q.push_back(cmd);
		crc = modbus_crc_step(crc, cmd);
		byte_q.push_back(len[7:0]);
		crc = modbus_crc_step(crc, len[7:0]);
		for (int i = 0; i < len; i++) begin
			d = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
			byte_q.push_back(d);
			crc = modbus_crc_step(crc, d);
		end
		if (corrupt) begin
			crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		end
		byte_q.push_back(crc[7:0]);
		byte_q.push_back(crc[15:8]);
	endtask

	task random_traffic(input int target);
		int taken;
		int kind;
		taken = 0;
		while (taken < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				add_frame(8'($urandom_range(0, 255)), pick_payload_len(), -1, 1'b0);
			end else if (kind < 70) begin
				add_frame(8'($urandom_range(0, 255)), pick_payload_len(), -1, 1'b1);
			end else if (kind < 76) begin
				byte_q.push_back(hdr_first);
				byte_q.push_back(hdr_second);
				byte_q.push_back(8'($urandom_range(0, 255)));
				byte_q.push_back(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
			end else if (kind < 84) begin
				repeat ($urandom_range(1, 3)) byte_q.push_back(hdr_first);
				add_frame(8'($urandom_range(0, 255)), pick_payload_len(), -1, 1'b0);
			end else if (kind < 90) begin
				byte_q.push_back(hdr_first);
				byte_q.push_back(hdr_second);
				repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(0, 255)));
			end
			if (kind < 90) begin
				taken += byte_q.size();
			end
			send_queued();
		end
	endtask

	task settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task set_headers(input logic [7:0] first, input logic [7:0] second);
		cfg_valid <= 1'b1;
		cfg_index <= REG_HEADER_FIRST;
		cfg_data <= first;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_HEADER_SECOND;
		cfg_data <= second;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		hdr_first = first;
		hdr_second = second;
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [7:0] v;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_HEADER_FIRST;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_frame(8'hFF, 0, -1, 1'b0);
		byte_q.push_back(hdr_first);
		add_frame(8'h00, 1, 8'hFF, 1'b0);
		byte_q.push_back(hdr_first);
		byte_q.push_back(8'h12);
		byte_q.push_back(hdr_first);
		byte_q.push_back(hdr_second);
		byte_q.push_back(8'h5A);
		byte_q.push_back(8'(MAX_PAYLOAD_DEF + 1));
		add_frame(8'h3C, 0, -1, 1'b1);
		send_queued();
		settle();

		v = 8'($urandom_range(0, 255));
		set_headers(v, v ^ 8'($urandom_range(1, 255)));
		rx_hold_req = 400;
		add_frame(8'($urandom_range(0, 255)), MAX_PAYLOAD_DEF, -1, 1'b0);
		add_frame(8'($urandom_range(0, 255)), 3, -1, 1'b0);
		send_queued();
		settle();

		set_headers(8'h00, 8'hFF);
		random_traffic(8);
		settle();

		tx_idle_pct = 86;
		rx_idle_pct = 20;
		set_headers(8'hFF, 8'h00);
		random_traffic(8);
		settle();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		v = 8'($urandom_range(0, 255));
		set_headers(v, v);
		random_traffic(8);
		settle();

		repeat (20) @(posedge clk);
		if (err_count == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
